FILE: hdl/chs_pkg.sv
// Package: shared types and constants for the chained hash set core.
package chs_pkg;

  localparam int DefNumBuckets = 64;
  localparam int DefCapacity   = 256;
  localparam int ElemW         = 32;
  localparam int CfgW          = 7;
  localparam int CountW        = 9;
  localparam int ResetBuckets  = 64;

  localparam logic FuncInsert = 1'b0;
  localparam logic FuncLookup = 1'b1;

  typedef struct packed {
    logic                    func;
    logic signed [ElemW-1:0] element;
  } in_t;

  typedef struct packed {
    logic              found;
    logic              added;
    logic              full_res;
    logic [CountW-1:0] element_count;
  } out_t;

endpackage

FILE: hdl/chs_ram.sv
// Generic single-write, single-read RAM with registered read data.
module chs_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                      wdata_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                      rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: hdl/chained_hash_set_core.sv
// Top level: hash set of signed 32-bit integers with separate chaining.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+------------------------------
//  in      | input     | in_valid_i/in_stall_o  | func, element
//  out     | output    | out_valid_o/out_stall_i| found, added, full_res, count
//  cfg     | input     | cfg_we_i               | bucket_count (clears the set)
//
// A transaction passes through the accept in StIdle, the bit-serial modulo (StMod), the
// head read (StHrd, StHchk), a read and check per chain node visited (StNrd, StNchk,
// each waiting on the registered RAM read), a write (StWr1) plus StWr2 when an insert
// links to a chain tail, and the output state (StOut).
// Reset and a bucket_count write clear head valid bits and the node counter
// at once; no clearing pass. Input stalls while a transaction is in work;
// the result holds on out_data_o while out_stall_i is high.
module chained_hash_set_core #(
  parameter int NUM_BUCKETS = chs_pkg::DefNumBuckets,
  parameter int CAPACITY    = chs_pkg::DefCapacity
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  chs_pkg::in_t                 in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output chs_pkg::out_t                out_data_o,
  input  logic                         cfg_we_i,
  input  logic [chs_pkg::CfgW-1:0]     cfg_wdata_i
);
  import chs_pkg::*;

  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int BW = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int NRst = (ResetBuckets > NUM_BUCKETS) ? NUM_BUCKETS : ResetBuckets;

  typedef enum logic [8:0] {
    StIdle = 9'b000000001,
    StMod  = 9'b000000010,
    StHrd  = 9'b000000100,
    StHchk = 9'b000001000,
    StNrd  = 9'b000010000,
    StNchk = 9'b000100000,
    StWr1  = 9'b001000000,
    StWr2  = 9'b010000000,
    StOut  = 9'b100000000
  } state_e;

  state_e            state_q, state_d;
  logic [CfgW-1:0]   n_q, n_d;
  logic [CfgW-1:0]   r_q, r_d;
  logic [ElemW-1:0]  sh_q, sh_d;
  logic [4:0]        step_q, step_d;
  logic              func_q, func_d;
  logic [ElemW-1:0]  elem_q, elem_d;
  logic [IW-1:0]     cur_q, cur_d;
  logic [IW-1:0]     last_q, last_d;
  logic              have_last_q, have_last_d;
  logic              found_q, found_d;
  logic              added_q, added_d;
  logic              full_q, full_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic [NUM_BUCKETS-1:0] hvalid_q, hvalid_d;

  logic [CfgW:0]     mod_t;
  logic [CfgW:0]     n_ext;
  logic [BW-1:0]     bkt;

  logic              head_we;
  logic [IW-1:0]     head_rdata;
  logic              val_we;
  logic [ElemW-1:0]  val_rdata;
  logic              link_we;
  logic [IW-1:0]     link_waddr;
  logic [IW:0]       link_wdata;
  logic [IW:0]       link_rdata;

  assign bkt   = BW'(r_q);
  assign n_ext = {1'b0, n_q};
  assign mod_t = {r_q, sh_q[ElemW-1]};

  chs_ram #(.Width(IW), .Depth(NUM_BUCKETS)) u_head (
    .clk_i   (clk_i),
    .we_i    (head_we),
    .waddr_i (bkt),
    .wdata_i (IW'(cnt_q)),
    .raddr_i (bkt),
    .rdata_o (head_rdata)
  );

  chs_ram #(.Width(ElemW), .Depth(CAPACITY)) u_value (
    .clk_i   (clk_i),
    .we_i    (val_we),
    .waddr_i (IW'(cnt_q)),
    .wdata_i (elem_q),
    .raddr_i (cur_q),
    .rdata_o (val_rdata)
  );

  chs_ram #(.Width(IW + 1), .Depth(CAPACITY)) u_link (
    .clk_i   (clk_i),
    .we_i    (link_we),
    .waddr_i (link_waddr),
    .wdata_i (link_wdata),
    .raddr_i (cur_q),
    .rdata_o (link_rdata)
  );

  always_comb begin
    state_d     = state_q;
    n_d         = n_q;
    r_d         = r_q;
    sh_d        = sh_q;
    step_d      = step_q;
    func_d      = func_q;
    elem_d      = elem_q;
    cur_d       = cur_q;
    last_d      = last_q;
    have_last_d = have_last_q;
    found_d     = found_q;
    added_d     = added_q;
    full_d      = full_q;
    cnt_d       = cnt_q;
    hvalid_d    = hvalid_q;
    head_we     = 1'b0;
    val_we      = 1'b0;
    link_we     = 1'b0;
    link_waddr  = IW'(cnt_q);
    link_wdata  = '0;

    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          func_d      = in_data_i.func;
          elem_d      = in_data_i.element;
          r_d         = in_data_i.element[ElemW-1] ? n_q - CfgW'(1) : '0;
          sh_d        = {in_data_i.element[ElemW-2:0], 1'b0};
          step_d      = '0;
          found_d     = 1'b0;
          added_d     = 1'b0;
          full_d      = 1'b0;
          have_last_d = 1'b0;
          state_d     = StMod;
        end
      end
      StMod: begin
        r_d    = (mod_t >= n_ext) ? CfgW'(mod_t - n_ext) : mod_t[CfgW-1:0];
        sh_d   = {sh_q[ElemW-2:0], 1'b0};
        step_d = step_q + 5'd1;
        if (step_q == 5'(ElemW - 2)) begin
          state_d = StHrd;
        end
      end
      StHrd: begin
        state_d = StHchk;
      end
      StHchk: begin
        if (hvalid_q[bkt]) begin
          cur_d   = head_rdata;
          state_d = StNrd;
        end else begin
          state_d = StWr1;
        end
      end
      StNrd: begin
        state_d = StNchk;
      end
      StNchk: begin
        if (val_rdata == elem_q) begin
          found_d = 1'b1;
          state_d = StWr1;
        end else begin
          have_last_d = 1'b1;
          last_d      = cur_q;
          if (link_rdata[IW]) begin
            cur_d   = link_rdata[IW-1:0];
            state_d = StNrd;
          end else begin
            state_d = StWr1;
          end
        end
      end
      StWr1: begin
        if (func_q == FuncInsert && !found_q) begin
          if (cnt_q == CW'(CAPACITY)) begin
            full_d  = 1'b1;
            state_d = StOut;
          end else begin
            val_we     = 1'b1;
            link_we    = 1'b1;
            link_wdata = '0;
            if (!have_last_q) begin
              head_we       = 1'b1;
              hvalid_d[bkt] = 1'b1;
              cnt_d         = cnt_q + CW'(1);
              added_d       = 1'b1;
              state_d       = StOut;
            end else begin
              state_d = StWr2;
            end
          end
        end else begin
          state_d = StOut;
        end
      end
      StWr2: begin
        link_we    = 1'b1;
        link_waddr = last_q;
        link_wdata = {1'b1, IW'(cnt_q)};
        cnt_d      = cnt_q + CW'(1);
        added_d    = 1'b1;
        state_d    = StOut;
      end
      StOut: begin
        if (!out_stall_i) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase

    if (cfg_we_i) begin
      if (cfg_wdata_i == '0) begin
        n_d = CfgW'(1);
      end else if (32'(cfg_wdata_i) > NUM_BUCKETS) begin
        n_d = CfgW'(NUM_BUCKETS);
      end else begin
        n_d = cfg_wdata_i;
      end
      hvalid_d = '0;
      cnt_d    = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      n_q      <= CfgW'(NRst);
      cnt_q    <= '0;
      hvalid_q <= '0;
    end else begin
      state_q  <= state_d;
      n_q      <= n_d;
      cnt_q    <= cnt_d;
      hvalid_q <= hvalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    r_q         <= r_d;
    sh_q        <= sh_d;
    step_q      <= step_d;
    func_q      <= func_d;
    elem_q      <= elem_d;
    cur_q       <= cur_d;
    last_q      <= last_d;
    have_last_q <= have_last_d;
    found_q     <= found_d;
    added_q     <= added_d;
    full_q      <= full_d;
  end

  assign in_stall_o  = (state_q != StIdle);
  assign out_valid_o = (state_q == StOut);
  assign out_data_o.found         = found_q;
  assign out_data_o.added         = added_q;
  assign out_data_o.full_res      = full_q;
  assign out_data_o.element_count = CountW'(cnt_q);

endmodule

FILE: test/chained_hash_set_core_tb.sv
// Testbench for chained_hash_set_core: directed and random insert/lookup traffic checked live.
module chained_hash_set_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import chs_pkg::*;

  localparam int NB = DefNumBuckets;
  localparam int CAP = DefCapacity;
  localparam longint CycleLimit = 5_000_000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  in_t in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  out_t out_data_o;
  logic cfg_we_i = 1'b0;
  logic [CfgW-1:0] cfg_wdata_i = '0;

  chained_hash_set_core dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // shadow hash set
  logic [CfgW-1:0] shadow_buckets;
  logic [ElemW-1:0] pool_value[CAP];
  int pool_link[CAP];
  bit pool_link_ok[CAP];
  int chain_head[NB];
  bit chain_head_ok[NB];
  int set_size, free_slot;

  out_t pending_results[$];
  logic signed [ElemW-1:0] recent[$];
  int errors = 0, n_sent = 0, n_checked = 0, n_full = 0, n_hits = 0;
  int stall_left = 0;
  bit quiet = 0;
  longint cycles = 0;

  function automatic void clear_shadow();
    for (int i = 0; i < NB; i++) chain_head_ok[i] = 0;
    for (int i = 0; i < CAP; i++) pool_link_ok[i] = 0;
    set_size = 0;
    free_slot = 0;
  endfunction

  function automatic int bucket_index(logic signed [ElemW-1:0] e);
    longint n, r;
    n = (shadow_buckets == 0) ? 1 : ((shadow_buckets > NB) ? NB : shadow_buckets);
    r = longint'(e) % n;
    if (r < 0) r += n;
    return int'(r);
  endfunction

  function automatic out_t predict_set_op(in_t t);
    out_t r;
    int b, cur, last, steps;
    bit ok, have_last;
    r = '0;
    b = bucket_index(t.element);
    ok = chain_head_ok[b];
    cur = chain_head[b];
    have_last = 0;
    last = 0;
    steps = 0;
    while (ok && steps < CAP) begin
      if (pool_value[cur] == t.element) begin
        r.found = 1'b1;
        break;
      end
      have_last = 1;
      last = cur;
      ok = pool_link_ok[cur];
      cur = pool_link[cur];
      steps++;
    end
    if (t.func == FuncInsert && !r.found) begin
      if (free_slot >= CAP) r.full_res = 1'b1;
      else begin
        pool_value[free_slot] = t.element;
        pool_link_ok[free_slot] = 0;
        if (have_last) begin
          pool_link[last] = free_slot;
          pool_link_ok[last] = 1;
        end else begin
          chain_head[b] = free_slot;
          chain_head_ok[b] = 1;
        end
        free_slot++;
        set_size++;
        r.added = 1'b1;
      end
    end
    r.element_count = set_size[CountW-1:0];
    return r;
  endfunction

  task automatic send_op(logic f, logic signed [ElemW-1:0] e);
    int gap;
    gap = quiet ? 0 : (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19));
    repeat (gap) @(negedge clk_i);
    in_data_i.func = f;
    in_data_i.element = e;
    in_valid_i = 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pending_results.push_back(predict_set_op(in_data_i));
    if (f == FuncInsert) recent.push_back(e);
    if (recent.size() > 64) void'(recent.pop_front());
    n_sent++;
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_buckets(logic [CfgW-1:0] v);
    wait_drained();
    cfg_wdata_i = v;
    cfg_we_i = 1'b1;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    shadow_buckets = v;
    clear_shadow();
    recent.delete();
  endtask

  function automatic logic signed [ElemW-1:0] pick_element();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return recent.size() ? recent[$urandom_range(0, recent.size() - 1)]
                                       : $urandom();
      4, 5: return $signed(ElemW'($urandom_range(0, 200))) - 100;
      default: return $urandom();
    endcase
  endfunction

  task automatic test_directed_edges();
    send_op(FuncLookup, 32'sh0);
    send_op(FuncInsert, 32'sh0);
    send_op(FuncInsert, 32'sh0);
    send_op(FuncInsert, -32'sd1);
    send_op(FuncInsert, 32'sh7FFF_FFFF);
    send_op(FuncInsert, 32'sh8000_0000);
    send_op(FuncInsert, 32'sh8000_0000);
    send_op(FuncInsert, -32'sd64);
    send_op(FuncInsert, 32'sd64);
    send_op(FuncInsert, 32'sd128);
    send_op(FuncLookup, 32'sd128);
    send_op(FuncLookup, -32'sd1);
    send_op(FuncLookup, 32'sh8000_0000);
    send_op(FuncLookup, 32'sh7FFF_FFFF);
    send_op(FuncLookup, 32'sh5555_5555);
    send_op(FuncLookup, 32'shAAAA_AAAA);
  endtask

  task automatic test_bucket_limits();
    write_buckets(7'd0);
    send_op(FuncInsert, -32'sd5);
    send_op(FuncInsert, 32'sd5);
    send_op(FuncLookup, -32'sd5);
    write_buckets(7'd127);
    send_op(FuncInsert, 32'sd100);
    send_op(FuncInsert, 32'sd36);
    send_op(FuncLookup, 32'sd100);
    write_buckets(7'd1);
    for (int i = 0; i < 20; i++) send_op(FuncInsert, pick_element());
    for (int i = 0; i < 10; i++) send_op(FuncLookup, pick_element());
  endtask

  task automatic test_pool_exhaustion();
    write_buckets(7'd64);
    while (free_slot < CAP) send_op(FuncInsert, $urandom());
    for (int i = 0; i < 12; i++) send_op(FuncInsert, $urandom());
    for (int i = 0; i < 8; i++) send_op(1'($urandom_range(0, 1)), pick_element());
  endtask

  task automatic test_random_traffic();
    logic [CfgW-1:0] settings[6] = '{7'd64, 7'd3, 7'd127, 7'd17, 7'd2, 7'd64};
    foreach (settings[p]) begin
      write_buckets(p == 4 ? CfgW'($urandom_range(0, 127)) : settings[p]);
      quiet = (p == 5);
      for (int i = 0; i < 137; i++) begin
        send_op($urandom_range(0, 2) == 0 ? FuncLookup : FuncInsert, pick_element());
        if (i == 60) wait_drained();
      end
    end
    quiet = 0;
  endtask

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout at %0t", $time);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      out_stall_i = 1'b1;
      stall_left--;
    end else out_stall_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      out_t want;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected transaction, actual %p", $time, out_data_o);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (out_data_o.found !== want.found) begin
          $display("%0t: found expected %0b actual %0b", $time, want.found, out_data_o.found);
          errors++;
        end
        if (out_data_o.added !== want.added) begin
          $display("%0t: added expected %0b actual %0b", $time, want.added, out_data_o.added);
          errors++;
        end
        if (out_data_o.full_res !== want.full_res) begin
          $display("%0t: full_res expected %0b actual %0b", $time, want.full_res,
                   out_data_o.full_res);
          errors++;
        end
        if (out_data_o.element_count !== want.element_count) begin
          $display("%0t: element_count expected %0d actual %0d", $time, want.element_count,
                   out_data_o.element_count);
          errors++;
        end
        if (want.full_res) n_full++;
        if (want.found) n_hits++;
      end
      n_checked++;
      stall_left = quiet ? 0 : (($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 19));
    end
  end

  initial begin
    int guard;
    shadow_buckets = CfgW'(ResetBuckets);
    clear_shadow();
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    test_directed_edges();
    test_bucket_limits();
    test_pool_exhaustion();
    test_random_traffic();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    guard = 0;
    while (pending_results.size() != 0 && guard < 100000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (100) @(posedge clk_i);
    if (pending_results.size() != 0) begin
      $display("%0d transactions never returned", pending_results.size());
      errors++;
    end
    $display("sent %0d ops, checked %0d results (%0d hits, %0d pool-full)",
             n_sent, n_checked, n_hits, n_full);
    $display("bucket counts 0..127 incl. saturation, pool exhaustion, %0d errors", errors);
    if (errors == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end
endmodule
